// ===== sv/bta_pkg.sv =====
// Package: shared types and constants of the bakery ticket lock arbiter.
`default_nettype none

package bta_pkg;

    localparam int CLIENTS_DEF     = 32;
    localparam int TICKET_BITS_DEF = 16;
    localparam int CFG_W           = 6;
    localparam int CLIENT_W        = 5;
    localparam int TICKET_OUT_W    = 16;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    typedef enum logic [1:0] {
        REQ_TAKE    = 2'd0,
        REQ_TRY     = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_NOP     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_NONE     = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OWN,
        S_SCAN,
        S_FINISH,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/bta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/bakery_ticket_lock_arbiter_unit.sv =====
// Top level: bakery ticket lock arbiter with a one-entry-per-cycle ticket scanner.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-------------------------------------
//  cfg     | in  | i_cfg_valid / o_cfg_ready  | i_cfg_clients_in_use (6b)
//  in      | in  | i_in_valid  / o_in_ready   | i_req_type (2b), i_client (5b)
//  out     | out | o_out_valid / i_out_ready  | o_granted, o_ticket (16b), o_status (2b)
//
// Sequence: a take scans every ticket RAM entry, a try scans the active entries (none
//   if the requester holds no ticket), release / out-of-range / type three skip the
//   scan. The scan reads one entry per cycle through the RAM's single read port.
// Reset: synchronous, active low; clears the sequencer, the output slot and the
//   per-entry valid bits, so every ticket reads as zero at once (no clearing pass).
// Stalls: a finished result waits in the output register; a new request is
//   taken while it waits, and the next result holds in S_DONE until the slot frees.
`default_nettype none

module bakery_ticket_lock_arbiter_unit import bta_pkg::*; #(
    parameter int CLIENTS     = CLIENTS_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration
    input  wire logic                    i_cfg_valid,
    output      logic                    o_cfg_ready,
    input  wire logic [CFG_W-1:0]        i_cfg_clients_in_use,
    // request channel
    input  wire logic                    i_in_valid,
    output      logic                    o_in_ready,
    input  wire logic [1:0]              i_req_type,
    input  wire logic [CLIENT_W-1:0]     i_client,
    // result channel
    output      logic                    o_out_valid,
    input  wire logic                    i_out_ready,
    output      logic                    o_granted,
    output      logic [TICKET_OUT_W-1:0] o_ticket,
    output      logic [1:0]              o_status
);

    localparam int IDX_W  = $clog2(CLIENTS);
    localparam int NCNT_W = $clog2(CLIENTS + 1);
    localparam int CNT_W  = (NCNT_W > CFG_W) ? NCNT_W : CFG_W;
    localparam logic [IDX_W-1:0]       LAST_ALL = IDX_W'(CLIENTS - 1);
    localparam logic [TICKET_BITS-1:0] TKT_MAX  = '1;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    logic [CFG_W-1:0]       r_cfg;
    t_req                   r_req;
    logic [CNT_W-1:0]       r_cli;
    logic [TICKET_BITS-1:0] r_mine;    // requester's own ticket
    logic [TICKET_BITS-1:0] r_acc;     // running maximum (take)
    logic                   r_deny;    // a smaller pair was seen (try)
    logic [IDX_W-1:0]       r_ptr;     // entry whose data is on the read port
    logic [IDX_W-1:0]       r_last;
    logic [CLIENTS-1:0]     r_valid;   // entry holds a written ticket
    logic                   r_rd_vld;  // valid bit aligned with RAM read data

    // pending result
    logic                   r_res_granted;
    logic [TICKET_BITS-1:0] r_res_ticket;
    t_status                r_res_status;

    // output slot
    logic                    r_o_valid;
    logic                    r_o_granted;
    logic [TICKET_OUT_W-1:0] r_o_ticket;
    t_status                 r_o_status;

    // ---------------------------------------------------------------
    // Derived values
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]       cfg_ext;
    logic [CNT_W-1:0]       n_act;     // active count, saturated at CLIENTS
    logic [CNT_W-1:0]       n_act_m1;
    logic [IDX_W-1:0]       cli_idx;
    logic                   out_free;
    logic                   in_acc;
    logic                   out_of_range;
    logic [TICKET_BITS-1:0] rd_tkt;
    logic [TICKET_BITS-1:0] next_tkt;
    logic                   smaller;
    logic [TICKET_BITS+TICKET_OUT_W-1:0] res_ext;

    // RAM control
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_raddr;
    logic [TICKET_BITS-1:0] ram_rdata;

    assign cfg_ext      = CNT_W'(r_cfg);
    assign n_act        = (cfg_ext > CNT_W'(CLIENTS)) ? CNT_W'(CLIENTS) : cfg_ext;
    assign n_act_m1     = n_act - CNT_W'(1);
    assign cli_idx      = r_cli[IDX_W-1:0];
    assign out_free     = !r_o_valid || i_out_ready;
    assign in_acc       = i_in_valid && o_in_ready;
    assign out_of_range = (r_cli >= n_act);
    assign rd_tkt       = r_rd_vld ? ram_rdata : '0;
    assign next_tkt     = r_acc + TICKET_BITS'(1);
    // another client's pair (t, j) orders ahead of ours
    assign smaller      = (rd_tkt != '0) && (r_ptr != cli_idx) &&
                          ((rd_tkt < r_mine) || ((rd_tkt == r_mine) && (r_ptr < cli_idx)));
    assign res_ext      = {{TICKET_OUT_W{1'b0}}, r_res_ticket};

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_OWN;
                end
            end
            S_OWN: begin
                if (out_of_range) begin
                    n_state = S_DONE;
                end else begin
                    case (r_req)
                        REQ_TAKE: n_state = S_SCAN;
                        REQ_TRY:  n_state = (rd_tkt == '0) ? S_DONE : S_SCAN;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_ptr == r_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Control outputs
    // ---------------------------------------------------------------
    always_comb begin
        ram_we    = 1'b0;
        ram_raddr = '0;
        case (r_state)
            S_IDLE: begin
                // read the requester's entry while the request is taken
                ram_raddr = IDX_W'(i_client);
            end
            S_OWN:  ram_raddr = '0;
            S_SCAN: ram_raddr = r_ptr + IDX_W'(1);
            S_FINISH: begin
                ram_we = (r_req == REQ_TAKE) && (r_acc != TKT_MAX);
            end
            default: ram_raddr = '0;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Ticket store
    // ---------------------------------------------------------------
    bta_ram #(
        .WIDTH (TICKET_BITS),
        .DEPTH (CLIENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cli_idx),
        .i_wdata (next_tkt),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg     <= CFG_RESET;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_clients_in_use;
            end
            if (ram_we) begin
                r_valid[cli_idx] <= 1'b1;
            end else if ((r_state == S_OWN) && !out_of_range &&
                         (r_req == REQ_RELEASE)) begin
                r_valid[cli_idx] <= 1'b0;
            end
            if ((r_state == S_DONE) && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_valid[ram_raddr];
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_req <= t_req'(i_req_type);
                    r_cli <= CNT_W'(i_client);
                end
            end
            S_OWN: begin
                r_mine        <= rd_tkt;
                r_ptr         <= '0;
                r_acc         <= '0;
                r_deny        <= 1'b0;
                r_res_granted <= 1'b0;
                r_last        <= (r_req == REQ_TAKE) ? LAST_ALL : n_act_m1[IDX_W-1:0];
                // only type three reports its ticket here; take and try fill it in later
                r_res_ticket  <= (!out_of_range && (r_req == REQ_NOP)) ? rd_tkt : '0;
                if (out_of_range) begin
                    r_res_status <= ST_RANGE;
                end else if (((r_req == REQ_TRY) || (r_req == REQ_RELEASE)) &&
                             (rd_tkt == '0)) begin
                    r_res_status <= ST_NONE;
                end else begin
                    r_res_status <= ST_OK;
                end
            end
            S_SCAN: begin
                r_ptr <= r_ptr + IDX_W'(1);
                if (rd_tkt > r_acc) begin
                    r_acc <= rd_tkt;
                end
                if (smaller) begin
                    r_deny <= 1'b1;
                end
            end
            S_FINISH: begin
                if (r_req == REQ_TAKE) begin
                    if (r_acc == TKT_MAX) begin
                        r_res_status <= ST_OVERFLOW;
                        r_res_ticket <= r_mine;
                    end else begin
                        r_res_ticket <= next_tkt;
                    end
                end else begin
                    r_res_granted <= !r_deny;
                    r_res_ticket  <= r_mine;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    r_o_granted <= r_res_granted;
                    r_o_ticket  <= res_ext[TICKET_OUT_W-1:0];
                    r_o_status  <= r_res_status;
                end
            end
            default: r_ptr <= '0;
        endcase
    end

    assign o_out_valid = r_o_valid;
    assign o_granted   = r_o_granted;
    assign o_ticket    = r_o_ticket;
    assign o_status    = r_o_status;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_write_only_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_FINISH) && (r_req == REQ_TAKE))
        else $error("ticket store written outside a take");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ptr <= r_last))
        else $error("scan pointer ran past the last entry");

    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted) |-> (o_status == ST_OK))
        else $error("grant with a non-ok status");

    a_range_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_RANGE)) |-> (o_ticket == '0) && !o_granted)
        else $error("out-of-range result carries data");

    a_take_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (r_valid[cli_idx] == 1'b1))
        else $error("valid bit not set after ticket write");

endmodule

`default_nettype wire

// ===== test/bakery_lock_monitor.sv =====
// Checker for the bakery lock arbiter: tracks tickets, predicts each answer, compares results.
module bakery_lock_monitor import bta_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [CFG_W-1:0]        i_cfg_clients_in_use,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic [CLIENT_W-1:0]     i_client,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_granted,
    input  logic [TICKET_OUT_W-1:0] i_ticket,
    input  logic [1:0]              i_status,
    output int                      o_err_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKET_MAX = (1 << TICKET_BITS_DEF) - 1;

    typedef struct packed {
        logic                    granted;
        logic [TICKET_OUT_W-1:0] ticket;
        t_status                 status;
    } lock_answer_t;

    logic [TICKET_BITS_DEF-1:0] held_ticket [CLIENTS_DEF];
    logic [CFG_W-1:0]           clients_in_use;
    lock_answer_t               awaited_answers [$];
    int                         err_count = 0;

    // Applies one request to the ticket copy and returns the answer it should produce.
    function automatic lock_answer_t serve_lock_request(input t_req kind, input int who);
        lock_answer_t ans;
        int           active;
        int           top_ticket;
        int           j;
        ans.granted = 1'b0;
        ans.ticket  = '0;
        ans.status  = ST_OK;
        active = (clients_in_use > CLIENTS_DEF) ? CLIENTS_DEF : int'(clients_in_use);
        if (who >= active) begin
            ans.status = ST_RANGE;
        end else begin
            case (kind)
                REQ_TAKE: begin
                    // largest ticket over every entry, active or not
                    top_ticket = 0;
                    for (j = 0; j < CLIENTS_DEF; j++) begin
                        if (int'(held_ticket[j]) > top_ticket) top_ticket = int'(held_ticket[j]);
                    end
                    if (top_ticket + 1 > TICKET_MAX) ans.status = ST_OVERFLOW;
                    else held_ticket[who] = TICKET_BITS_DEF'(top_ticket + 1);
                    ans.ticket = held_ticket[who][TICKET_OUT_W-1:0];
                end
                REQ_TRY: begin
                    if (held_ticket[who] == '0) begin
                        ans.status = ST_NONE;
                    end else begin
                        ans.granted = 1'b1;
                        for (j = 0; j < active; j++) begin
                            if (j != who && held_ticket[j] != '0 &&
                                (held_ticket[j] < held_ticket[who] ||
                                 (held_ticket[j] == held_ticket[who] && j < who)))
                                ans.granted = 1'b0;
                        end
                        ans.ticket = held_ticket[who][TICKET_OUT_W-1:0];
                    end
                end
                REQ_RELEASE: begin
                    if (held_ticket[who] == '0) ans.status = ST_NONE;
                    else held_ticket[who] = '0;
                end
                default: begin
                    ans.ticket = held_ticket[who][TICKET_OUT_W-1:0];
                end
            endcase
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        lock_answer_t want;
        int           k;
        if (!i_rst_n) begin
            for (k = 0; k < CLIENTS_DEF; k++) held_ticket[k] = '0;
            clients_in_use = CFG_RESET;
            awaited_answers.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) clients_in_use = i_cfg_clients_in_use;
            if (i_in_valid && i_in_ready)
                awaited_answers.push_back(serve_lock_request(t_req'(i_req_type), int'(i_client)));
            if (i_out_valid && i_out_ready) begin
                if (awaited_answers.size() == 0) begin
                    $error("result with no request pending: granted %0d ticket %0d status %0d",
                           i_granted, i_ticket, i_status);
                    err_count++;
                end else begin
                    want = awaited_answers.pop_front();
                    if (i_granted !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, i_granted);
                        err_count++;
                    end
                    if (i_ticket !== want.ticket) begin
                        $error("ticket: expected %0d, got %0d", want.ticket, i_ticket);
                        err_count++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        err_count++;
                    end
                end
            end
        end
        o_pending   <= awaited_answers.size();
        o_err_count <= err_count;
    end

endmodule

// ===== test/tb_top.sv =====
// Testbench top: drives requests and register writes into the lock arbiter, gives the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bta_pkg::*;

    localparam int RANDOM_ITEMS   = 1090;
    localparam int HOLD_CYCLES    = 300;    // long result stall, fills the block up
    localparam int DRAIN_CYCLES   = 40;     // a little more than one take scan
    localparam int WATCHDOG_LIMIT = 1000;

    logic                    i_clk                = 1'b0;
    logic                    i_rst_n              = 1'b0;
    logic                    i_cfg_valid          = 1'b0;
    logic [CFG_W-1:0]        i_cfg_clients_in_use = CFG_RESET;
    logic                    i_in_valid           = 1'b0;
    logic [1:0]              i_req_type           = REQ_TAKE;
    logic [CLIENT_W-1:0]     i_client             = '0;
    logic                    i_out_ready          = 1'b0;
    logic                    o_cfg_ready;
    logic                    o_in_ready;
    logic                    o_out_valid;
    logic                    o_granted;
    logic [TICKET_OUT_W-1:0] o_ticket;
    logic [1:0]              o_status;

    int mismatch_count;
    int answers_due;
    int idle_cycles = 0;

    // Shared between the request side and the result side.
    bit quiet_gaps = 1'b0;  // no idling on either side while set
    bit long_hold  = 1'b0;  // result side takes one long stall at its next request

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    bakery_ticket_lock_arbiter_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_clients_in_use (i_cfg_clients_in_use),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_req_type           (i_req_type),
        .i_client             (i_client),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_granted            (o_granted),
        .o_ticket             (o_ticket),
        .o_status             (o_status)
    );

    bakery_lock_monitor monitor (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_ready          (o_cfg_ready),
        .i_cfg_clients_in_use (i_cfg_clients_in_use),
        .i_in_valid           (i_in_valid),
        .i_in_ready           (o_in_ready),
        .i_req_type           (i_req_type),
        .i_client             (i_client),
        .i_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .i_granted            (o_granted),
        .i_ticket             (o_ticket),
        .i_status             (o_status),
        .o_err_count          (mismatch_count),
        .o_pending            (answers_due)
    );

    // One request. Valid stays up across back-to-back requests; it only drops for a gap.
    // Outputs are sampled at the edge before the block's own updates land, so ready seen
    // here is the value the handshake used.
    task automatic send_req(input t_req kind, input logic [CLIENT_W-1:0] who);
        int gap;
        gap = quiet_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_client   <= who;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every predicted answer has come back. Every request
    // yields exactly one result, so an empty queue means the block is idle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (answers_due != 0);
    endtask

    // Register write, only ever issued from the idle state.
    task automatic write_clients(input logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_valid          <= 1'b1;
        i_cfg_clients_in_use <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Result side: random stall per result, plus the occasional long hold-off while the
    // request side keeps pushing.
    initial begin : result_sink
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end
            gap = quiet_gaps ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Watchdog: any cycle with a handshake on some channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                  phase;
        int                  span;
        int                  left;
        int                  roll;
        int                  active_now;
        int                  k;
        logic [CFG_W-1:0]    setting;
        t_req                kind;
        logic [CLIENT_W-1:0] who;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part, register at its reset value (all 32 clients active) ----
        send_req(REQ_TRY, 5'd0);        // try without a ticket
        send_req(REQ_RELEASE, 5'd0);    // release without a ticket
        send_req(REQ_TAKE, 5'd0);       // first ticket
        send_req(REQ_TAKE, 5'd31);      // highest client index
        send_req(REQ_TAKE, 5'd0);       // take while holding: jumps past client 31
        send_req(REQ_TRY, 5'd31);       // smallest ticket, should enter
        send_req(REQ_TRY, 5'd0);        // blocked by client 31
        send_req(REQ_NOP, 5'd31);       // type three: reports current ticket only
        send_req(REQ_RELEASE, 5'd31);
        send_req(REQ_TRY, 5'd0);        // now alone, should enter

        // no active clients: everything answers out of range
        write_clients(6'd0);
        send_req(REQ_TAKE, 5'd0);
        send_req(REQ_TRY, 5'd31);
        send_req(REQ_RELEASE, 5'd5);

        // all ones: active count saturates at the client count
        write_clients(6'd63);
        send_req(REQ_TAKE, 5'd31);
        send_req(REQ_TRY, 5'd31);

        // single active client: client 31 still holds a ticket that the take must see,
        // but the try only compares client 0 against itself
        write_clients(6'd1);
        send_req(REQ_TAKE, 5'd1);
        send_req(REQ_TAKE, 5'd0);
        send_req(REQ_TRY, 5'd0);

        write_clients(6'd32);
        send_req(REQ_RELEASE, 5'd0);
        send_req(REQ_RELEASE, 5'd31);
        send_req(REQ_NOP, 5'd0);

        // ---- random part: phases of take / try / release traffic ----
        // Mostly a handful of active clients so tickets contend and grants happen;
        // now and then the full range or an arbitrary register value.
        left  = RANDOM_ITEMS;
        phase = 0;
        while (left > 0) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) setting = CFG_W'($urandom_range(0, 63));
            else if (roll == 1) setting = CFG_W'(CLIENTS_DEF);
            else setting = CFG_W'($urandom_range(2, 6));
            write_clients(setting);
            active_now = (setting > CLIENTS_DEF) ? CLIENTS_DEF : int'(setting);

            quiet_gaps = ($urandom_range(0, 3) == 0);
            if (phase == 2 || $urandom_range(0, 7) == 0) begin
                // results stall for a long while and requests pile up behind them
                long_hold  = 1'b1;
                quiet_gaps = 1'b1;
            end

            span = $urandom_range(30, 120);
            while (span > 0 && left > 0) begin
                roll = $urandom_range(0, 19);
                if (roll < 7) kind = REQ_TAKE;
                else if (roll < 14) kind = REQ_TRY;
                else if (roll < 19) kind = REQ_RELEASE;
                else kind = REQ_NOP;

                // some requests from clients beyond the active count
                if (active_now == 0 || (active_now < CLIENTS_DEF && $urandom_range(0, 9) == 0))
                    who = CLIENT_W'($urandom_range(active_now, CLIENTS_DEF - 1));
                else
                    who = CLIENT_W'($urandom_range(0, active_now - 1));

                send_req(kind, who);
                span--;
                left--;
            end
            phase++;
        end

        // ---- wrap-up: empty the store, numbering restarts from one ----
        write_clients(6'd32);
        quiet_gaps = 1'b0;
        for (k = 0; k < CLIENTS_DEF; k++) send_req(REQ_RELEASE, CLIENT_W'(k));
        send_req(REQ_TAKE, 5'd2);
        send_req(REQ_TRY, 5'd2);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && answers_due == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
